// ===== sv/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap queue unit.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int CAPACITY    = 64;
	localparam int KEY_BITS    = 32;
	localparam int HANDLE_BITS = 16;
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int ENTRY_W     = KEY_BITS + HANDLE_BITS;

	localparam logic       REQ_INSERT = 1'b0;
	localparam logic       REQ_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic   req_type;
		entry_t ent;
	} req_t;

endpackage

// ===== sv/bmhq_front.sv =====
// ----------------------------------------------------------------------------
// bmhq_front
// Accepts request words and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module bmhq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bmhq_pkg::req_t in_req,
	output logic          q_valid,
	input  logic          q_ready,
	output bmhq_pkg::req_t q_req
);
	import bmhq_pkg::*;

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = slot_q[rd_ptr_q];
	assign push     = in_valid & in_ready;
	assign pop      = q_valid & q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== sv/bmhq_back.sv =====
// ----------------------------------------------------------------------------
// bmhq_back
// Heap engine: sift-up and sift-down over a one-read one-write memory,
// with a result register toward the output.
// ----------------------------------------------------------------------------
module bmhq_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         q_ready,
	input  bmhq_pkg::req_t               q_req,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [1:0]                   res_status,
	output bmhq_pkg::entry_t             res_ent,
	output logic [bmhq_pkg::CNT_W-1:0]   res_count
);
	import bmhq_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INS_CMP = 4'd1;
	localparam logic [3:0] S_INS_WR  = 4'd2;
	localparam logic [3:0] S_RM_ROOT = 4'd3;
	localparam logic [3:0] S_RM_LAST = 4'd4;
	localparam logic [3:0] S_SD_RL   = 4'd5;
	localparam logic [3:0] S_SD_RR   = 4'd6;
	localparam logic [3:0] S_SD_CMP  = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	entry_t              mem [CAPACITY];
	entry_t              rd_q;
	logic [3:0]          state_q;
	logic [CNT_W-1:0]    fill_q;
	logic [ADDR_W-1:0]   pos_q;
	entry_t              cur_q;
	entry_t              lft_q;
	logic                rv_q;
	logic [1:0]          status_q;
	entry_t              oent_q;
	logic                out_valid_q;
	logic [1:0]          rstat_q;
	entry_t              rent_q;
	logic [CNT_W-1:0]    rcnt_q;

	logic                we;
	logic [ADDR_W-1:0]   wa;
	entry_t              wd;
	logic [ADDR_W-1:0]   ra;
	logic [ADDR_W-1:0]   up;
	logic [ADDR_W+1:0]   lc;
	logic [ADDR_W+1:0]   rc;
	logic [CNT_W-1:0]    fill_m1;
	logic                take_l;
	logic                take_r;
	entry_t              pick_l;
	logic                res_load;

	assign up      = ADDR_W'((pos_q - 1'b1) >> 1);
	assign lc      = {1'b0, pos_q, 1'b1};
	assign rc      = {1'b0, pos_q, 1'b0} + (ADDR_W+2)'(2);
	assign fill_m1 = fill_q - 1'b1;
	assign take_l  = (lft_q.key < cur_q.key);
	assign pick_l  = take_l ? lft_q : cur_q;
	assign take_r  = rv_q & (rd_q.key < pick_l.key);
	assign q_ready = (state_q == S_IDLE);

	// load the result register once the previous word has left
	assign res_load = (state_q == S_DONE) & (!out_valid_q | res_ready);

	assign res_valid  = out_valid_q;
	assign res_status = rstat_q;
	assign res_ent    = rent_q;
	assign res_count  = rcnt_q;

	always_comb begin
		we = 1'b0;
		wa = pos_q;
		wd = cur_q;
		ra = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q_req.req_type == REQ_INSERT) begin
					ra = ADDR_W'((fill_q - 1'b1) >> 1);
					wa = ADDR_W'(fill_q);
					wd = q_req.ent;
					we = q_valid & (fill_q == CNT_W'(0));
				end else begin
					ra = '0;
				end
			end
			S_INS_CMP: begin
				ra = ADDR_W'((up - 1'b1) >> 1);
				we = 1'b1;
				wd = (cur_q.key < rd_q.key) ? rd_q : cur_q;
			end
			S_INS_WR:  we = 1'b1;
			S_RM_ROOT: ra = ADDR_W'(fill_m1);
			S_RM_LAST: ra = '0;
			S_SD_RL: begin
				ra = lc[ADDR_W-1:0];
				we = (lc >= (ADDR_W+2)'(fill_q));
			end
			S_SD_RR:   ra = rc[ADDR_W-1:0];
			S_SD_CMP: begin
				we = 1'b1;
				wd = take_r ? rd_q : pick_l;
			end
			S_DONE:    ra = '0;
			default:   ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rstat_q <= status_q;
			rent_q  <= oent_q;
			rcnt_q  <= fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						oent_q   <= '0;
						status_q <= ST_OK;
						cur_q    <= q_req.ent;
						pos_q    <= ADDR_W'(fill_q);
						if (q_req.req_type == REQ_INSERT) begin
							if (fill_q == CNT_W'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								fill_q  <= fill_q + 1'b1;
								state_q <= (fill_q == CNT_W'(0)) ? S_DONE : S_INS_CMP;
							end
						end else if (fill_q == CNT_W'(0)) begin
							status_q <= ST_EMPTY;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_RM_ROOT;
						end
					end
				end
				S_INS_CMP: begin
					// move parent down while the new key is strictly smaller
					if (cur_q.key < rd_q.key) begin
						pos_q   <= up;
						state_q <= (up == ADDR_W'(0)) ? S_INS_WR : S_INS_CMP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_INS_WR: state_q <= S_DONE;
				S_RM_ROOT: begin
					oent_q  <= rd_q;
					fill_q  <= fill_m1;
					state_q <= S_RM_LAST;
				end
				S_RM_LAST: begin
					cur_q   <= rd_q;
					pos_q   <= '0;
					state_q <= (fill_q == CNT_W'(0)) ? S_DONE : S_SD_RL;
				end
				S_SD_RL: begin
					state_q <= (lc >= (ADDR_W+2)'(fill_q)) ? S_DONE : S_SD_RR;
				end
				S_SD_RR: begin
					lft_q   <= rd_q;
					rv_q    <= (rc < (ADDR_W+2)'(fill_q));
					state_q <= S_SD_CMP;
				end
				S_SD_CMP: begin
					if (take_r) begin
						pos_q   <= rc[ADDR_W-1:0];
						state_q <= S_SD_RL;
					end else if (take_l) begin
						pos_q   <= lc[ADDR_W-1:0];
						state_q <= S_SD_RL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/binary_min_heap_queue_unit.sv =====
// A full insert, an empty remove or an insert into an empty heap goes straight to the
// result, and a remove of the only entry does not sift; other inserts climb the heap and
// other removes descend it a level at a time over one memory read port, until a compare
// stops the sift. The engine takes a new word only once the previous result is in the
// result register; a two-word queue and that register decouple stalls.
// Reset: arst_n clears the fill count and all handshake state; heap memory is left as is.
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit
// Binary min-heap priority queue of key and handle pairs.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // entry_key[31:0], entry_handle[47:32]
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // out_key, out_handle, entry_count, is_empty
	output logic [1:0]  m_axis_tuser   // status
);
	import bmhq_pkg::*;

	req_t             in_req;
	req_t             q_req;
	logic             q_valid;
	logic             q_ready;
	entry_t           res_ent;
	logic [CNT_W-1:0] res_count;

	// unpack the request word
	assign in_req.req_type   = s_axis_tuser;
	assign in_req.ent.key    = s_axis_tdata[KEY_BITS-1:0];
	assign in_req.ent.handle = s_axis_tdata[KEY_BITS +: HANDLE_BITS];

	bmhq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_req   (in_req),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_req    (q_req)
	);

	bmhq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_req      (q_req),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_status (m_axis_tuser),
		.res_ent    (res_ent),
		.res_count  (res_count)
	);

	// pack the result word; empty flag follows the count
	assign m_axis_tdata = {(res_count == CNT_W'(0)), res_count, res_ent.handle, res_ent.key};

endmodule
